>>> rtl/core/ist_pkg.sv
// Shared types and constants for the integer set table.
// No dependencies; every other file of the block imports this package.
package ist_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 5;

	// Operation codes carried in the kind field. Code 3 acts as a query.
	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Operation token that walks down the cell chain.
	typedef struct packed {
		logic                      valid;
		logic [1:0]                kind;
		logic signed [VALUE_W-1:0] value;
		logic                      hit;
		logic                      free_seen;
	} tok_t;

	// Broadcast from the controller to every cell at the end of an operation.
	typedef struct packed {
		logic finish;
		logic commit;
	} cell_ctl_t;

endpackage

>>> rtl/core/ist_req_if.sv
// Request channel of the integer set table: valid/ready plus one operation word.
// Depends on ist_pkg for field widths.
interface ist_req_if;
	import ist_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

>>> rtl/core/ist_rsp_if.sv
// Response channel of the integer set table: valid/ready plus one result word.
// Depends on ist_pkg for field widths.
interface ist_rsp_if;
	import ist_pkg::*;

	logic               valid;
	logic               ready;
	logic               was_present;
	logic               dropped_full;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output was_present, output dropped_full, output count,
		input ready);
	modport sink (input valid, input was_present, input dropped_full, input count,
		output ready);
endinterface

>>> rtl/core/ist_cell.sv
// One entry of the set table: stored value, valid bit and a reservation flag.
// Passes the operation token on to its neighbor each cycle. Depends on ist_pkg.
module ist_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ist_pkg::tok_t      tok_prev,
	input  ist_pkg::cell_ctl_t ctl,
	output ist_pkg::tok_t      tok_next,
	output logic               entry_valid,
	output logic               entry_reserved
);
	import ist_pkg::*;

	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_q;
	logic                      reserved_q;
	tok_t                      tok_q;
	tok_t                      tok_d;
	logic                      match;
	logic                      do_remove;
	logic                      do_reserve;

	// Compare the passing word against this entry and decide the local action.
	always_comb begin
		match      = valid_q && (value_q == tok_prev.value);
		do_remove  = tok_prev.valid && (tok_prev.kind == KIND_REMOVE) && match;
		do_reserve = tok_prev.valid && (tok_prev.kind == KIND_ADD) && !valid_q &&
			!tok_prev.free_seen;
		tok_d           = tok_prev;
		tok_d.hit       = tok_prev.hit | match;
		tok_d.free_seen = tok_prev.free_seen | !valid_q;
	end

	// Control state: valid bit, reservation and the forwarded token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			reserved_q <= 1'b0;
			tok_q      <= '0;
		end else begin
			tok_q <= tok_d;
			if (do_remove) begin
				valid_q <= 1'b0;
			end else if (ctl.finish && ctl.commit && reserved_q) begin
				valid_q <= 1'b1;
			end
			if (do_reserve) begin
				reserved_q <= 1'b1;
			end else if (ctl.finish) begin
				reserved_q <= 1'b0;
			end
		end
	end

	// The value is written into a free entry when it is reserved; it only
	// becomes visible once the valid bit is set at commit.
	always_ff @(posedge clk) begin
		if (do_reserve) begin
			value_q <= tok_prev.value;
		end
	end

	assign tok_next       = tok_q;
	assign entry_valid    = valid_q;
	assign entry_reserved = reserved_q;

endmodule

>>> rtl/core/integer_set_table.sv
// Integer set table: holds up to CAPACITY distinct 32-bit values and answers
// add, remove and membership requests, one at a time. Each request word walks
// down a chain of CAPACITY entry cells, one cell per cycle; the outcome is then
// registered in fin_q, and the result register is loaded once the sink has room
// for it, after which the controller returns to idle and takes the next request.
// The chain length sets how long a request takes, and a sink that holds back a
// finished result delays both the result word and the next request.
// An add that finds the value absent takes the lowest-numbered free entry, or
// is reported as dropped when the table is full. The result word sits in an
// output register, so a new request is taken while an earlier result still
// waits for the sink. Count is the element count after the operation, kept to
// its low five bits.
// Depends on ist_pkg, ist_req_if, ist_rsp_if and ist_cell.
module integer_set_table #(
	parameter int CAPACITY = ist_pkg::DEF_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	ist_req_if.sink    req,
	ist_rsp_if.source  rsp
);
	import ist_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	tok_t                 chain [CAPACITY+1];
	logic [CAPACITY-1:0]  valid_vec;
	logic [CAPACITY-1:0]  reserved_vec;
	logic [CAPACITY:0]    tok_valid_vec;
	cell_ctl_t            ctl;

	state_t               state_q;
	state_t               state_d;
	tok_t                 fin_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_d;
	logic                 load_out;
	logic                 is_add;
	logic                 is_remove;
	logic [CNT_W+COUNT_W-1:0] cnt_wide;

	logic                 rsp_valid_q;
	logic                 was_q;
	logic                 drop_q;
	logic [COUNT_W-1:0]   rcnt_q;

	// Token entering the chain on an accepted request word.
	always_comb begin
		chain[0]           = '0;
		chain[0].valid     = req.valid && req.ready;
		chain[0].kind      = req.kind;
		chain[0].value     = req.value;
		chain[0].hit       = 1'b0;
		chain[0].free_seen = 1'b0;
	end

	// Row of entry cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ist_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.tok_prev       (chain[i]),
			.ctl            (ctl),
			.tok_next       (chain[i+1]),
			.entry_valid    (valid_vec[i]),
			.entry_reserved (reserved_vec[i])
		);
	end

	for (genvar i = 0; i <= CAPACITY; i++) begin : g_tokv
		assign tok_valid_vec[i] = chain[i].valid;
	end

	assign req.ready = (state_q == ST_IDLE);
	assign is_add    = (fin_q.kind == KIND_ADD);
	assign is_remove = (fin_q.kind == KIND_REMOVE);

	// Next state, commit broadcast and count update.
	always_comb begin
		state_d    = state_q;
		ctl.finish = 1'b0;
		ctl.commit = 1'b0;
		load_out   = 1'b0;
		cnt_d      = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (chain[CAPACITY].valid) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					ctl.finish = 1'b1;
					ctl.commit = is_add && !fin_q.hit && fin_q.free_seen;
					load_out   = 1'b1;
					state_d    = ST_IDLE;
					if (ctl.commit) begin
						cnt_d = cnt_q + 1'b1;
					end else if (is_remove && fin_q.hit) begin
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign cnt_wide = (CNT_W + COUNT_W)'(cnt_d);

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Scan outcome and result word.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && chain[CAPACITY].valid) begin
			fin_q <= chain[CAPACITY];
		end
		if (load_out) begin
			was_q  <= fin_q.hit;
			drop_q <= is_add && !fin_q.hit && !fin_q.free_seen;
			rcnt_q <= cnt_wide[COUNT_W-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.was_present  = was_q;
	assign rsp.dropped_full = drop_q;
	assign rsp.count        = rcnt_q;

	// The count never exceeds the table size.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// Between requests the count matches the number of valid entries.
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> $countones(valid_vec) == int'(cnt_q))
		else $error("element count does not match valid entries");

	// At most one entry is reserved for a pending add.
	a_one_reserve: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(reserved_vec))
		else $error("more than one entry reserved");

	// Only one request travels the chain at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid_vec))
		else $error("more than one token in the chain");

	// A drop is reported only when the table was full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && is_add && !fin_q.hit && !fin_q.free_seen |->
		cnt_q == CNT_W'(CAPACITY))
		else $error("add dropped while table not full");

endmodule

>>> verif/ist_set_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the integer set table: mirrors the table contents from accepted
// request words and checks every response word, in order, against its prediction.
// Depends on ist_pkg, ist_req_if and ist_rsp_if.
module ist_set_checker (
	input  logic clk,
	input  logic arst_n,
	ist_req_if   req,
	ist_rsp_if   rsp,
	output int   fail_count,
	output int   pending_words
);
	import ist_pkg::*;

	typedef struct packed {
		logic               was_present;
		logic               dropped_full;
		logic [COUNT_W-1:0] count;
	} set_result_t;

	// Mirror of the table: one value and one occupied flag per entry.
	logic signed [VALUE_W-1:0] slot_value [DEF_CAPACITY];
	logic                      slot_used  [DEF_CAPACITY];
	int                        member_count;
	set_result_t               expected_q [$];
	int                        fail_total;

	// Applies one operation to the mirror and returns the response word it should produce.
	// The unused kind code falls through to the query branch and changes nothing.
	function automatic set_result_t apply_set_op(input logic [1:0] op,
		input logic signed [VALUE_W-1:0] v);
		int          hit;
		int          free_slot;
		int          i;
		set_result_t r;
		hit = -1;
		free_slot = -1;
		for (i = 0; i < DEF_CAPACITY; i++) begin
			if (slot_used[i] && slot_value[i] == v && hit < 0)
				hit = i;
			if (!slot_used[i] && free_slot < 0)
				free_slot = i;
		end
		r.dropped_full = 1'b0;
		case (op)
			KIND_ADD: begin
				if (hit < 0) begin
					if (free_slot < 0) begin
						r.dropped_full = 1'b1;
					end else begin
						slot_value[free_slot] = v;
						slot_used[free_slot] = 1'b1;
						member_count++;
					end
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					slot_used[hit] = 1'b0;
					member_count--;
				end
			end
			default: begin
			end
		endcase
		r.was_present = (hit >= 0);
		r.count = member_count[COUNT_W-1:0];
		return r;
	endfunction

	// Responses are checked before the request of the same edge is predicted, so a
	// response can never be matched against a request taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		set_result_t want;
		int          i;
		if (!arst_n) begin
			for (i = 0; i < DEF_CAPACITY; i++) begin
				slot_value[i] = '0;
				slot_used[i] = 1'b0;
			end
			member_count = 0;
			expected_q.delete();
			fail_total = 0;
			fail_count <= 0;
			pending_words <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display({"%0t: response word with none expected ",
						"(was_present %0d, dropped_full %0d, count %0d)"},
						$time, rsp.was_present, rsp.dropped_full, rsp.count);
					fail_total++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.was_present !== want.was_present) begin
						$display("%0t: was_present expected %0d, got %0d",
							$time, want.was_present, rsp.was_present);
						fail_total++;
					end
					if (rsp.dropped_full !== want.dropped_full) begin
						$display("%0t: dropped_full expected %0d, got %0d",
							$time, want.dropped_full, rsp.dropped_full);
						fail_total++;
					end
					if (rsp.count !== want.count) begin
						$display("%0t: count expected %0d, got %0d",
							$time, want.count, rsp.count);
						fail_total++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(apply_set_op(req.kind, req.value));
			fail_count <= fail_total;
			pending_words <= expected_q.size();
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top of the integer set table testbench: clock, reset, request stimulus in bursts,
// response back-pressure, a watchdog and the verdict.
// Depends on ist_pkg, ist_req_if, ist_rsp_if, integer_set_table and ist_set_checker.
module tb;
	import ist_pkg::*;

	localparam logic [1:0] KIND_SPARE   = 2'd3;    // unused code, answered as a query
	localparam int         RANDOM_ITEMS = 1750;
	localparam int         POOL_SIZE    = 24;      // more values than entries, so the table fills
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         DRAIN_CYCLES = 2 * (DEF_CAPACITY + 2);
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;
	int   burst_left;

	logic signed [VALUE_W-1:0] pool [POOL_SIZE];

	ist_req_if req ();
	ist_rsp_if rsp ();

	integer_set_table #(.CAPACITY(DEF_CAPACITY)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ist_set_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.fail_count    (fails),
		.pending_words (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Presents one request word and holds it until the table takes it.
	task automatic send_word(input logic [1:0] op, input logic signed [VALUE_W-1:0] v);
		req.valid <= 1'b1;
		req.kind  <= op;
		req.value <= v;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Sends one word as part of a burst; a random gap, sometimes none, opens between bursts.
	task automatic issue(input logic [1:0] op, input logic signed [VALUE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		send_word(op, v);
	endtask

	// Picks an operation with a bias that depends on the current phase of the run.
	function automatic logic [1:0] draw_kind(input op_mix_t mix);
		int r;
		int add_top;
		int remove_top;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				add_top = 75;
				remove_top = 87;
			end
			MIX_DRAIN: begin
				add_top = 20;
				remove_top = 85;
			end
			default: begin
				add_top = 45;
				remove_top = 75;
			end
		endcase
		if (r < 5)
			return KIND_SPARE;
		else if (r < add_top)
			return KIND_ADD;
		else if (r < remove_top)
			return KIND_REMOVE;
		else
			return KIND_QUERY;
	endfunction

	// Adds use the pool only, so stored values get removed again; lookups and
	// removes sometimes use a fully random value, which is almost always absent.
	function automatic logic signed [VALUE_W-1:0] draw_value(input logic [1:0] op);
		if (op == KIND_ADD || $urandom_range(0, 99) >= 15)
			return pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			return $urandom;
	endfunction

	// Response back-pressure: a rotating ready pattern, changed at random intervals.
	// Bit 0 is always set, so no stall lasts longer than the pattern width.
	initial begin
		int          hold;
		logic [15:0] pattern;
		rsp.ready <= 1'b0;
		hold = 0;
		pattern = '1;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				hold = $urandom_range(8, 120);
				case ($urandom_range(0, 2))
					0: pattern = '1;
					1: pattern = 16'($urandom);
					default: pattern = 16'($urandom & $urandom);
				endcase
				pattern[0] = 1'b1;
			end
			hold--;
			rsp.ready <= pattern[0];
			pattern = {pattern[0], pattern[15:1]};
		end
	end

	// Watchdog: ends the run when no word moves on either channel for too long.
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle = 0;
			else
				idle++;
		end
		$display("integer_set_table: mismatch");
		$finish;
	end

	// Reset, directed words, random words, drain and verdict.
	initial begin
		int      n;
		int      j;
		int      mix_left;
		op_mix_t mix;
		logic [1:0] op;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= KIND_QUERY;
		req.value <= '0;
		burst_left = 0;
		mix_left = 0;
		mix = MIX_EVEN;
		for (j = 0; j < POOL_SIZE; j++)
			pool[j] = $urandom;
		pool[0] = VALUE_MIN;
		pool[1] = VALUE_MAX;
		pool[2] = '0;
		pool[3] = -1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lookups and removes on the empty table.
		issue(KIND_QUERY, 32'sd5);
		issue(KIND_REMOVE, 32'sd7);
		// Extreme values, a repeated add, and the unused kind code.
		issue(KIND_ADD, VALUE_MIN);
		issue(KIND_ADD, VALUE_MAX);
		issue(KIND_ADD, '0);
		issue(KIND_ADD, -1);
		issue(KIND_ADD, VALUE_MAX);
		issue(KIND_QUERY, VALUE_MIN);
		issue(KIND_SPARE, VALUE_MAX);
		// Remove a present value, then remove it again once it is gone.
		issue(KIND_REMOVE, '0);
		issue(KIND_REMOVE, '0);
		// Fill the table, add to it while full, then free one entry and reuse it.
		for (j = 1; j <= DEF_CAPACITY - 3; j++)
			issue(KIND_ADD, j * 32'sh1111_1111);
		issue(KIND_ADD, 32'sd12345);
		issue(KIND_ADD, -1);
		issue(KIND_REMOVE, VALUE_MIN);
		issue(KIND_ADD, 32'sd12345);

		// Random part in phases that favor filling, draining or neither.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 49) == 0) begin
				// Retire one pool value from the table before replacing it.
				j = $urandom_range(0, POOL_SIZE - 1);
				issue(KIND_REMOVE, pool[j]);
				pool[j] = $urandom;
			end
			if (mix_left == 0) begin
				mix_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: mix = MIX_FILL;
					1: mix = MIX_DRAIN;
					default: mix = MIX_EVEN;
				endcase
			end
			mix_left--;
			op = draw_kind(mix);
			issue(op, draw_value(op));
		end
		req.valid <= 1'b0;

		// Wait for every outstanding response, then watch for strays.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("integer_set_table: match");
		else
			$display("integer_set_table: mismatch");
		$finish;
	end

endmodule
